@@ sv/lecw_pkg.sv @@
package lecw_pkg;

   localparam int POSITION_BITS  = 16;
   localparam int NUM_TRACKED    = 6;
   localparam int MASK_BITS      = 6;
   localparam int MASK_VALUES    = 1 << MASK_BITS;
   localparam int CHAR_BITS      = 8;
   localparam int LEN_BITS       = 16;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_CNT_BITS = QUEUE_PTR_BITS + 1;

   typedef logic [MASK_BITS-1:0]                      mask_type;
   typedef logic [POSITION_BITS-1:0]                  position_type;
   typedef logic [CHAR_BITS-1:0]                      char_type;
   typedef logic [NUM_TRACKED-1:0][CHAR_BITS-1:0]     tracked_type;

   localparam position_type POS_MAX = {POSITION_BITS{1'b1}};
   localparam mask_type     MASK_ZERO = '0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_LIMIT = CSR_ADDR_BITS'(NUM_TRACKED);

   // tracked characters after reset: a b c x y z
   localparam tracked_type TRACKED_RESET = {8'd122, 8'd121, 8'd120, 8'd99, 8'd98, 8'd97};

   typedef struct packed {
      mask_type     mask;
      position_type pos;
      logic         last;
      logic         ovf;
   } item_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   // lowest matching register wins
   function automatic mask_type flip_mask(input char_type ch, input tracked_type tracked);
      mask_type flip;
      logic     found;
      flip  = '0;
      found = 1'b0;
      for (int k = 0; k < NUM_TRACKED; k++) begin
         if (!found && tracked[k] == ch) begin
            flip[k] = 1'b1;
            found   = 1'b1;
         end
      end
      return flip;
   endfunction

endpackage

@@ sv/lecw_front.sv @@
module lecw_front
   import lecw_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [CHAR_BITS-1:0]     req_tdata,
   input  logic                     req_tlast,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CHAR_BITS-1:0]     csr_wdata,
   input  queue_status_type         q_status,
   output logic                     push,
   output item_type                 push_item
);

   tracked_type  tracked_ff;
   position_type pos_ff;
   mask_type     mask_ff;
   logic         ovf_ff;

   position_type pos_in;
   mask_type     mask_in;
   logic         ovf_in;
   logic         sat;

   assign req_tready = !q_status.full;
   assign push       = req_tvalid && !q_status.full;

   always_comb begin
      sat       = (pos_ff == POS_MAX);
      pos_in    = sat ? pos_ff : pos_ff + 1'b1;
      ovf_in    = ovf_ff | sat;
      mask_in   = mask_ff ^ flip_mask(req_tdata, tracked_ff);
      push_item = '{mask: mask_in, pos: pos_in, last: req_tlast, ovf: ovf_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tracked_ff <= TRACKED_RESET;
      end else if (csr_we && csr_addr < CSR_LIMIT) begin
         tracked_ff[csr_addr] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         mask_ff <= '0;
         ovf_ff  <= 1'b0;
      end else if (push) begin
         if (req_tlast) begin
            pos_ff  <= '0;
            mask_ff <= '0;
            ovf_ff  <= 1'b0;
         end else begin
            pos_ff  <= pos_in;
            mask_ff <= mask_in;
            ovf_ff  <= ovf_in;
         end
      end
   end

endmodule

@@ sv/lecw_queue.sv @@
module lecw_queue
   import lecw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  item_type         push_item,
   input  logic             pop,
   output item_type         head,
   output queue_status_type status
);

   item_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_BITS-1:0] count_ff;

   assign head             = entry_ff[rd_ptr_ff];
   assign status.full      = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign status.not_empty = (count_ff != '0);

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

@@ sv/lecw_back.sv @@
module lecw_back
   import lecw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  item_type            head,
   input  queue_status_type    q_status,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [LEN_BITS-1:0] rsp_tdata,
   output logic                rsp_tlast,
   output logic                rsp_tuser
);

   position_type             first_pos_mem [MASK_VALUES];
   logic [MASK_VALUES-1:0]   seen_ff;

   logic                     s2_valid_ff;
   position_type             s2_start_ff;
   position_type             s2_pos_ff;
   logic                     s2_hit_ff;
   logic                     s2_zero_ff;
   logic                     s2_last_ff;
   logic                     s2_ovf_ff;

   position_type             best_ff;
   logic                     rsp_valid_ff;
   logic [LEN_BITS-1:0]      rsp_data_ff;
   logic                     rsp_last_ff;
   logic                     rsp_ovf_ff;

   logic                     adv;
   logic                     hit;
   logic                     is_zero;
   position_type             start;
   position_type             len;
   position_type             best_in;
   logic [POSITION_BITS+LEN_BITS-1:0] best_ext;
   logic [LEN_BITS-1:0]      rsp_data_in;

   assign adv     = !rsp_valid_ff || rsp_tready;
   assign pop     = q_status.not_empty && adv;
   assign is_zero = (head.mask == MASK_ZERO);
   assign hit     = is_zero || seen_ff[head.mask];

   // first position table, written on first sight of a nonzero mask
   always_ff @(posedge clock) begin
      if (pop && !hit) begin
         first_pos_mem[head.mask] <= head.pos;
      end
      if (pop) begin
         s2_start_ff <= first_pos_mem[head.mask];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else if (pop) begin
         if (head.last) begin
            seen_ff <= '0;
         end else if (!hit) begin
            seen_ff[head.mask] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s2_pos_ff  <= head.pos;
         s2_hit_ff  <= hit;
         s2_zero_ff <= is_zero;
         s2_last_ff <= head.last;
         s2_ovf_ff  <= head.ovf;
      end
   end

   always_comb begin
      start    = s2_zero_ff ? '0 : s2_start_ff;
      len      = (s2_hit_ff && s2_pos_ff >= start) ? s2_pos_ff - start : '0;
      best_in  = (len > best_ff) ? len : best_ff;
      best_ext = {{LEN_BITS{1'b0}}, best_in};
      rsp_data_in = (|best_ext[POSITION_BITS+LEN_BITS-1:LEN_BITS]) ? {LEN_BITS{1'b1}}
                                                                  : best_ext[LEN_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff <= '0;
      end else if (adv && s2_valid_ff) begin
         best_ff <= s2_last_ff ? '0 : best_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s2_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= s2_last_ff;
         rsp_ovf_ff  <= s2_ovf_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ovf_ff;

endmodule

@@ sv/longest_even_count_window.sv @@
// channel   direction  tdata                 tlast            tuser
// req_      in         [7:0] char_byte       last_char        -
// rsp_      out        [15:0] longest_window end_of_string    [0] length_overflow
// csr_      in         csr_wdata [7:0] into tracked_char_<csr_addr>, write only
//
// one transaction per cycle sustained on both sides while rsp_tready is held high
// an accepted req passes through a queue entry, the s2 registers and the rsp registers before rsp valid
// front updates mask and position, a four-entry queue feeds the back end
// back end does table lookup, subtract and compare over two register stages
// synchronous active-high reset; tracked chars reset to a b c x y z
// rsp stalls back up through the queue into req_tready
module longest_even_count_window
   import lecw_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [CHAR_BITS-1:0]     req_tdata,  // [7:0] char_byte
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [LEN_BITS-1:0]      rsp_tdata,  // [15:0] longest_window
   output logic                     rsp_tlast,
   output logic                     rsp_tuser,  // [0] length_overflow
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CHAR_BITS-1:0]     csr_wdata
);

   logic             push;
   logic             pop;
   item_type         push_item;
   item_type         head;
   queue_status_type q_status;

   lecw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .q_status   (q_status),
      .push       (push),
      .push_item  (push_item)
   );

   lecw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   lecw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ tb/sv/even_window_checker.sv @@
module even_window_checker
   import lecw_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [CHAR_BITS-1:0]     req_tdata,
   input  logic                     req_tlast,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [LEN_BITS-1:0]      rsp_tdata,
   input  logic                     rsp_tlast,
   input  logic                     rsp_tuser,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CHAR_BITS-1:0]     csr_wdata,
   output int                       mismatch_count,
   output int                       pending_count
);

   localparam int unsigned WINDOW_MAX = (1 << LEN_BITS) - 1;

   typedef struct packed {
      logic [LEN_BITS-1:0] window;
      logic                end_flag;
      logic                overflow;
   } window_result_type;

   tracked_type       tracked;
   mask_type          parity;
   position_type      char_pos;
   position_type      first_pos [MASK_VALUES];
   logic              mask_seen [MASK_VALUES];
   int unsigned       best_window;
   logic              pos_saturated;
   window_result_type expected_windows [$];

   function automatic void clear_string();
      parity        = MASK_ZERO;
      char_pos      = '0;
      best_window   = 0;
      pos_saturated = 1'b0;
      for (int m = 0; m < MASK_VALUES; m++) begin
         mask_seen[m] = 1'b0;
         first_pos[m] = '0;
      end
      mask_seen[MASK_ZERO] = 1'b1;
   endfunction

   function automatic window_result_type predict_window(input char_type ch, input logic last);
      window_result_type result;
      logic              matched;
      int unsigned       span;
      matched = 1'b0;
      if (char_pos == POS_MAX)
         pos_saturated = 1'b1;
      else
         char_pos = char_pos + 1'b1;
      // lowest matching register wins
      for (int k = 0; k < NUM_TRACKED; k++) begin
         if (!matched && tracked[k] == ch) begin
            parity[k] = ~parity[k];
            matched   = 1'b1;
         end
      end
      if (mask_seen[parity]) begin
         span = (char_pos >= first_pos[parity]) ? int'(char_pos - first_pos[parity]) : 0;
         if (span > best_window)
            best_window = span;
      end else begin
         mask_seen[parity] = 1'b1;
         first_pos[parity] = char_pos;
      end
      result.window   = (best_window > WINDOW_MAX) ? '1 : best_window[LEN_BITS-1:0];
      result.end_flag = last;
      result.overflow = pos_saturated;
      if (last)
         clear_string();
      return result;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t rsp error: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      window_result_type want;
      window_result_type fresh;
      if (reset) begin
         tracked        = TRACKED_RESET;
         mismatch_count = 0;
         clear_string();
         expected_windows.delete();
      end else begin
         if (csr_we && csr_addr < CSR_LIMIT)
            tracked[csr_addr] = csr_wdata;
         if (req_tvalid && req_tready) begin
            fresh            = predict_window(req_tdata, req_tlast);
            expected_windows = {expected_windows, fresh};
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_windows.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction window %0d last %0d ovf %0d",
                                         rsp_tdata, rsp_tlast, rsp_tuser));
            end else begin
               want = expected_windows.pop_front();
               if (rsp_tdata !== want.window || rsp_tlast !== want.end_flag ||
                   rsp_tuser !== want.overflow)
                  report_mismatch($sformatf(
                     "window exp %0d got %0d, last exp %0d got %0d, ovf exp %0d got %0d",
                     want.window, rsp_tdata, want.end_flag, rsp_tlast,
                     want.overflow, rsp_tuser));
            end
         end
      end
      pending_count = expected_windows.size();
   end

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
   import lecw_pkg::*;

   localparam int QUIET_LIMIT   = 2000;
   localparam int PHASE_ITEMS   = 455;
   localparam int SATURATE_LEN  = (1 << POSITION_BITS) + 4;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [CHAR_BITS-1:0]     req_tdata  = '0;
   logic                     req_tlast  = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [LEN_BITS-1:0]      rsp_tdata;
   logic                     rsp_tlast;
   logic                     rsp_tuser;
   logic                     csr_we     = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr   = '0;
   logic [CHAR_BITS-1:0]     csr_wdata  = '0;

   int          mismatch_count;
   int          pending_count;
   int          send_idle_pct = 0;
   int          stall_pct     = 0;
   int          hold_off_left = 0;
   int          quiet_cycles  = 0;
   tracked_type tracked_now   = TRACKED_RESET;

   longest_even_count_window DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   even_window_checker window_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver side, with an optional long hold-off
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_left > 0) begin
            rsp_tready <= 1'b0;
            hold_off_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("longest_even_count_window: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_char(input char_type ch, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0)
         @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_tracked(input tracked_type values);
      for (int i = 0; i < NUM_TRACKED; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= i[CSR_ADDR_BITS-1:0];
         csr_wdata <= values[i];
         @(negedge clock);
      end
      // indexes past the last register must be ignored
      for (int a = NUM_TRACKED; a < (1 << CSR_ADDR_BITS); a++) begin
         csr_addr  <= a[CSR_ADDR_BITS-1:0];
         csr_wdata <= char_type'($urandom_range(255));
         @(negedge clock);
      end
      csr_we      <= 1'b0;
      tracked_now  = values;
      @(negedge clock);
   endtask

   function automatic char_type pick_char();
      if ($urandom_range(99) < 70)
         return tracked_now[CSR_ADDR_BITS'($urandom_range(NUM_TRACKED - 1))];
      return char_type'($urandom_range(255));
   endfunction

   task automatic run_random(input int idle_pct, input int stall, input int count);
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      for (int n = 0; n < count; n++) begin
         if (n == count / 4 && idle_pct == 0 && stall == 0)
            hold_off_left = 60;
         // string lengths vary between a handful and several dozen characters
         send_char(pick_char(), $urandom_range(($urandom_range(3) == 0) ? 40 : 8) == 0);
      end
   endtask

   initial begin
      tracked_type cfg;
      string       directed;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset config: lowest and highest byte, each tracked char, then unwinding, then short strings and random traffic
      directed = "abcxyzzyxcba";
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b0);
      foreach (directed[i])
         send_char(directed[i], 1'b0);
      send_char("q", 1'b1);
      send_char("a", 1'b1);
      send_char("a", 1'b0);
      send_char("a", 1'b1);
      send_char("m", 1'b0);
      send_char("b", 1'b0);
      send_char("m", 1'b1);
      run_random(0, 0, PHASE_ITEMS);

      // position saturation with a string of untracked characters
      for (int n = 0; n < SATURATE_LEN; n++)
         send_char(char_type'($urandom_range(96)), n == SATURATE_LEN - 1);
      wait_drained();

      // extremes, with repeated registers so the lowest index must win
      write_tracked({8'd1, 8'd128, 8'hFF, 8'h00, 8'hFF, 8'h00});
      run_random(74, 0, PHASE_ITEMS);
      wait_drained();

      for (int k = 0; k < NUM_TRACKED; k++)
         cfg[k] = char_type'($urandom_range(255));
      write_tracked(cfg);
      run_random(0, 74, PHASE_ITEMS);
      wait_drained();

      cfg = {NUM_TRACKED{char_type'($urandom_range(255))}};
      write_tracked(cfg);
      run_random(17, 17, PHASE_ITEMS / 2);
      wait_drained();

      write_tracked({8'hFF, 8'hFE, 8'h80, 8'h7F, 8'h01, 8'h00});
      run_random(17, 17, PHASE_ITEMS / 2);
      wait_drained();

      if (mismatch_count == 0)
         $display("longest_even_count_window: match");
      else
         $display("longest_even_count_window: mismatch");
      $finish;
   end

endmodule
